FILE: hdl/sfcb_pkg.sv
// ----------------------------------------------------------------------------
// sfcb_pkg
// Beat types and fixed field widths of the Shannon-Fano code builder.
// ----------------------------------------------------------------------------
package sfcb_pkg;

	localparam int unsigned CODE_W  = 64;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned TOTAL_W = 22;

	typedef struct packed {
		logic [15:0] character;
		logic        last;
	} in_t;

	typedef struct packed {
		logic [15:0]        symbol;
		logic [15:0]        occurrences;
		logic [CODE_W-1:0]  code_bits;
		logic [LEN_W-1:0]   code_length;
		logic [TOTAL_W-1:0] total_bits;
		logic               overflow;
		logic               final_res;
	} out_t;

endpackage

FILE: hdl/shannon_fano_code_builder.sv
// ----------------------------------------------------------------------------
// shannon_fano_code_builder
// Histogram, rank sort and range-stack split over on-chip memories.
// ----------------------------------------------------------------------------
// Each character is looked up by a linear scan of the n known symbols
// through the symbol memory, stopping at a match. After the last character
// the rank sort and, for two or more symbols, the range splits run, and the
// n results then leave on consecutive cycles, one per symbol in sorted order.
// A new character is taken only when busy is low; results cannot be stalled.
// Reset: arst_n clears the control state; memories are not cleared.
// ----------------------------------------------------------------------------
module shannon_fano_code_builder #(
	parameter int unsigned MAX_SYMBOLS = 64,
	parameter int unsigned CHAR_BITS   = 16,
	parameter int unsigned COUNT_BITS  = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  sfcb_pkg::in_t   item,
	output logic            strobe,
	output sfcb_pkg::out_t  result
);
	import sfcb_pkg::*;

	localparam int unsigned IW = $clog2(MAX_SYMBOLS);
	localparam int unsigned NW = IW + 1;
	localparam int unsigned TW = COUNT_BITS + IW + 2;
	localparam int unsigned PW = COUNT_BITS + LEN_W;
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
	localparam logic [NW-1:0] NMAX = NW'(MAX_SYMBOLS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_RLD   = 4'd2;
	localparam logic [3:0] S_RCAP  = 4'd3;
	localparam logic [3:0] S_RCMP  = 4'd4;
	localparam logic [3:0] S_RWR   = 4'd5;
	localparam logic [3:0] S_PINIT = 4'd6;
	localparam logic [3:0] S_POP   = 4'd7;
	localparam logic [3:0] S_POPW  = 4'd8;
	localparam logic [3:0] S_SUM   = 4'd9;
	localparam logic [3:0] S_PRE   = 4'd10;
	localparam logic [3:0] S_UPD   = 4'd11;
	localparam logic [3:0] S_PUSH1 = 4'd12;
	localparam logic [3:0] S_PUSH2 = 4'd13;
	localparam logic [3:0] S_OUT   = 4'd14;

	logic [3:0]            state_q;
	logic [NW-1:0]         n_q, ra_q, lim_q, sp_q;
	logic                  ovf_q, pv_q, last_q;
	logic [IW-1:0]         pa_q, i_q, rank_q, s_q, e_q, cut_q;
	logic [CHAR_BITS-1:0]  ch_q, si_q;
	logic [COUNT_BITS-1:0] ci_q;
	logic [TW-1:0]         total_q, prefix_q, best_q;

	logic [CHAR_BITS-1:0]  usym_mem [MAX_SYMBOLS];
	logic [COUNT_BITS-1:0] ucnt_mem [MAX_SYMBOLS];
	logic [CHAR_BITS-1:0]  ssym_mem [MAX_SYMBOLS];
	logic [COUNT_BITS-1:0] scnt_mem [MAX_SYMBOLS];
	logic [CODE_W-1:0]     code_mem [MAX_SYMBOLS];
	logic [LEN_W-1:0]      len_mem  [MAX_SYMBOLS];
	logic [2*IW-1:0]       stk_mem  [MAX_SYMBOLS];

	logic [CHAR_BITS-1:0]  usym_rd, ssym_rd;
	logic [COUNT_BITS-1:0] ucnt_rd, scnt_rd;
	logic [CODE_W-1:0]     code_rd;
	logic [LEN_W-1:0]      len_rd;
	logic [2*IW-1:0]       stk_rd;

	logic [IW-1:0]         rd_addr, stk_ra;
	logic                  issue, scan_done, hit;
	logic                  u_we, s_we, c_we, st_we;
	logic [IW-1:0]         u_wa, c_wa, st_wa;
	logic [COUNT_BITS-1:0] u_wcnt;
	logic [CODE_W-1:0]     c_wcode;
	logic [LEN_W-1:0]      c_wlen;
	logic [2*IW-1:0]       st_wd;
	logic                  precedes, gap_less;
	logic [TW-1:0]         np, twice, gap;
	logic [PW-1:0]         prod;
	logic                  push_lo, push_hi;

	assign busy      = (state_q != S_IDLE);
	assign issue     = (ra_q < lim_q);
	assign scan_done = !issue && !pv_q;
	assign hit       = pv_q && (usym_rd == ch_q);
	assign rd_addr   = (state_q == S_RLD) ? i_q : ra_q[IW-1:0];
	assign stk_ra    = IW'(sp_q - NW'(1));
	assign precedes  = (ucnt_rd > ci_q) || ((ucnt_rd == ci_q) && (usym_rd < si_q));
	assign np        = prefix_q + TW'(scnt_rd);
	assign twice     = np << 1;
	assign gap       = (twice > total_q) ? (twice - total_q) : (total_q - twice);
	assign gap_less  = gap < best_q;
	assign prod      = PW'(len_rd) * PW'(scnt_rd);
	assign push_lo   = (cut_q > s_q) && (sp_q < NMAX);
	assign push_hi   = ({1'b0, e_q} > ({1'b0, cut_q} + NW'(1))) && (sp_q < NMAX);

	always_comb begin
		u_we    = 1'b0;
		u_wa    = pa_q;
		u_wcnt  = (ucnt_rd == CMAX) ? ucnt_rd : ucnt_rd + COUNT_BITS'(1);
		s_we    = 1'b0;
		c_we    = 1'b0;
		c_wa    = pa_q;
		c_wcode = {code_rd[CODE_W-2:0], (pa_q > cut_q)};
		c_wlen  = len_rd + LEN_W'(1);
		st_we   = 1'b0;
		st_wa   = sp_q[IW-1:0];
		st_wd   = {s_q, cut_q};
		unique case (state_q)
			S_SCAN: begin
				if (hit) begin
					u_we = 1'b1;
				end else if (scan_done && (n_q < NMAX)) begin
					u_we   = 1'b1;
					u_wa   = n_q[IW-1:0];
					u_wcnt = COUNT_BITS'(1);
				end
			end
			S_RWR: begin
				s_we    = 1'b1;
				c_we    = 1'b1;
				c_wa    = rank_q;
				c_wcode = '0;
				c_wlen  = '0;
			end
			S_PINIT: begin
				st_we = 1'b1;
				st_wa = '0;
				st_wd = {IW'(0), IW'(n_q - NW'(1))};
			end
			S_UPD:   c_we = pv_q;
			S_PUSH1: st_we = push_lo;
			S_PUSH2: begin
				st_we = push_hi;
				st_wd = {IW'(cut_q + IW'(1)), e_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (u_we) begin
			usym_mem[u_wa] <= ch_q;
			ucnt_mem[u_wa] <= u_wcnt;
		end
		if (s_we) begin
			ssym_mem[rank_q] <= si_q;
			scnt_mem[rank_q] <= ci_q;
		end
		if (c_we) begin
			code_mem[c_wa] <= c_wcode;
			len_mem[c_wa]  <= c_wlen;
		end
		if (st_we) begin
			stk_mem[st_wa] <= st_wd;
		end
		usym_rd <= usym_mem[rd_addr];
		ucnt_rd <= ucnt_mem[rd_addr];
		ssym_rd <= ssym_mem[rd_addr];
		scnt_rd <= scnt_mem[rd_addr];
		code_rd <= code_mem[rd_addr];
		len_rd  <= len_mem[rd_addr];
		stk_rd  <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && pv_q) begin
			result.symbol      <= 16'(ssym_rd);
			result.occurrences <= 16'(scnt_rd);
			result.code_bits   <= code_rd;
			result.code_length <= len_rd;
			result.total_bits  <= TOTAL_W'(prod);
			result.overflow    <= ovf_q;
			result.final_res   <= ({1'b0, pa_q} == (n_q - NW'(1)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			ovf_q   <= 1'b0;
			pv_q    <= 1'b0;
			ra_q    <= '0;
			lim_q   <= '0;
			sp_q    <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			pv_q   <= 1'b0;
			if (issue) begin
				ra_q <= ra_q + NW'(1);
				pa_q <= ra_q[IW-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						ch_q    <= CHAR_BITS'(item.character);
						last_q  <= item.last;
						ra_q    <= '0;
						lim_q   <= n_q;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					pv_q <= issue;
					if (hit || scan_done) begin
						pv_q  <= 1'b0;
						lim_q <= '0;
						if (!hit) begin
							if (n_q < NMAX) n_q <= n_q + NW'(1);
							else ovf_q <= 1'b1;
						end
						i_q     <= '0;
						state_q <= last_q ? S_RLD : S_IDLE;
					end
				end
				S_RLD: state_q <= S_RCAP;
				S_RCAP: begin
					si_q    <= usym_rd;
					ci_q    <= ucnt_rd;
					rank_q  <= '0;
					ra_q    <= '0;
					lim_q   <= n_q;
					state_q <= S_RCMP;
				end
				S_RCMP: begin
					pv_q <= issue;
					if (pv_q && precedes) rank_q <= rank_q + IW'(1);
					if (scan_done) state_q <= S_RWR;
				end
				S_RWR: begin
					i_q <= i_q + IW'(1);
					if ({1'b0, i_q} + NW'(1) == n_q) begin
						state_q <= (n_q < NW'(2)) ? S_OUT : S_PINIT;
						ra_q    <= '0;
						lim_q   <= n_q;
					end else begin
						state_q <= S_RLD;
					end
				end
				S_PINIT: begin
					sp_q    <= NW'(1);
					ra_q    <= '0;
					lim_q   <= '0;
					state_q <= S_POP;
				end
				S_POP: begin
					if (sp_q == '0) begin
						ra_q    <= '0;
						lim_q   <= n_q;
						state_q <= S_OUT;
					end else begin
						sp_q    <= sp_q - NW'(1);
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					s_q <= stk_rd[2*IW-1:IW];
					e_q <= stk_rd[IW-1:0];
					if (stk_rd[2*IW-1:IW] >= stk_rd[IW-1:0]) begin
						state_q <= S_POP;
					end else begin
						ra_q    <= {1'b0, stk_rd[2*IW-1:IW]};
						lim_q   <= {1'b0, stk_rd[IW-1:0]} + NW'(1);
						total_q <= '0;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					pv_q <= issue;
					if (pv_q) total_q <= total_q + TW'(scnt_rd);
					if (scan_done) begin
						ra_q     <= {1'b0, s_q};
						lim_q    <= {1'b0, e_q};
						prefix_q <= '0;
						best_q   <= total_q;
						cut_q    <= s_q;
						state_q  <= S_PRE;
					end
				end
				S_PRE: begin
					pv_q <= issue;
					if (pv_q) begin
						prefix_q <= np;
						if (gap_less) begin
							best_q <= gap;
							cut_q  <= pa_q;
						end
					end
					if (scan_done || (pv_q && !gap_less)) begin
						pv_q    <= 1'b0;
						ra_q    <= {1'b0, s_q};
						lim_q   <= {1'b0, e_q} + NW'(1);
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					pv_q <= issue;
					if (scan_done) state_q <= S_PUSH1;
				end
				S_PUSH1: begin
					if (push_lo) sp_q <= sp_q + NW'(1);
					state_q <= S_PUSH2;
				end
				S_PUSH2: begin
					if (push_hi) sp_q <= sp_q + NW'(1);
					state_q <= S_POP;
				end
				S_OUT: begin
					pv_q <= issue;
					if (pv_q) strobe <= 1'b1;
					if (scan_done) begin
						n_q     <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/sfcb_checker.sv
// ----------------------------------------------------------------------------
// sfcb_checker
// Port-level checks of the code builder, bound to the top level.
// ----------------------------------------------------------------------------
module sfcb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input sfcb_pkg::in_t  item,
	input logic           strobe,
	input sfcb_pkg::out_t result
);
	import sfcb_pkg::*;

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result beat while idle");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.final_res |=> strobe) else $error("gap in result burst");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.final_res |=> !busy && !strobe)
		else $error("not idle after final beat");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !item.last |=> !strobe) else $error("result without last");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> result.occurrences != '0) else $error("zero count emitted");

endmodule

bind shannon_fano_code_builder sfcb_checker u_sfcb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.strobe (strobe),
	.result (result)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Shannon-Fano code builder. Messages of random
// characters are sent through the start/busy handshake. A scoreboard keeps a
// mirror histogram, builds the codes on each last beat and checks every
// strobed result in order.
// ----------------------------------------------------------------------------
class sfcb_scoreboard;
	sfcb_pkg::out_t pending_codes[$];
	logic [15:0] sym_tab[64];
	logic [15:0] cnt_tab[64];
	int unsigned n_used;
	bit ovf_seen;
	int unsigned errors;

	function void note_beat(sfcb_pkg::in_t b);
		int unsigned i, j, sp, s, e, cut, total, prefix, best, twice, gap;
		bit found;
		logic [15:0] ts, tc;
		logic [63:0] code[64];
		logic [5:0] len[64];
		int unsigned stk_s[64], stk_e[64];
		sfcb_pkg::out_t r;
		found = 0;
		for (i = 0; i < n_used; i++) begin
			if (!found && sym_tab[i] == b.character) begin
				if (cnt_tab[i] != 16'hFFFF) cnt_tab[i]++;
				found = 1;
			end
		end
		if (!found) begin
			if (n_used < 64) begin
				sym_tab[n_used] = b.character;
				cnt_tab[n_used] = 16'd1;
				n_used++;
			end else begin
				ovf_seen = 1;
			end
		end
		if (!b.last) return;
		for (i = 1; i < n_used; i++) begin
			ts = sym_tab[i];
			tc = cnt_tab[i];
			j = i;
			while (j > 0 && (cnt_tab[j-1] < tc ||
				(cnt_tab[j-1] == tc && sym_tab[j-1] > ts))) begin
				sym_tab[j] = sym_tab[j-1];
				cnt_tab[j] = cnt_tab[j-1];
				j--;
			end
			sym_tab[j] = ts;
			cnt_tab[j] = tc;
		end
		for (i = 0; i < 64; i++) begin
			code[i] = '0;
			len[i] = '0;
		end
		sp = 0;
		if (n_used >= 2) begin
			stk_s[0] = 0;
			stk_e[0] = n_used - 1;
			sp = 1;
		end
		while (sp > 0) begin
			sp--;
			s = stk_s[sp];
			e = stk_e[sp];
			cut = s;
			if (s < e) begin
				total = 0;
				prefix = 0;
				for (i = s; i <= e; i++) total += cnt_tab[i];
				best = total;
				for (i = s; i < e; i++) begin
					prefix += cnt_tab[i];
					twice = prefix * 2;
					gap = (twice > total) ? twice - total : total - twice;
					if (gap < best) begin
						best = gap;
						cut = i;
					end else begin
						break;
					end
				end
				for (i = s; i <= e; i++) begin
					code[i] = {code[i][62:0], i > cut};
					len[i] = len[i] + 6'd1;
				end
				if (cut > s && sp < 64) begin
					stk_s[sp] = s;
					stk_e[sp] = cut;
					sp++;
				end
				if (e > cut + 1 && sp < 64) begin
					stk_s[sp] = cut + 1;
					stk_e[sp] = e;
					sp++;
				end
			end
		end
		for (i = 0; i < n_used; i++) begin
			r.symbol = sym_tab[i];
			r.occurrences = cnt_tab[i];
			r.code_bits = code[i];
			r.code_length = len[i];
			r.total_bits = 22'(int'(len[i]) * int'(cnt_tab[i]));
			r.overflow = ovf_seen;
			r.final_res = (i + 1 == n_used);
			pending_codes.push_back(r);
		end
		n_used = 0;
		ovf_seen = 0;
	endfunction

	function void check_result(sfcb_pkg::out_t got);
		sfcb_pkg::out_t want;
		if (pending_codes.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result %h", got);
			return;
		end
		want = pending_codes.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display({"mismatch sym %h/%h cnt %h/%h code %h/%h len %0d/%0d",
					" tot %0d/%0d ovf %b/%b fin %b/%b"},
					want.symbol, got.symbol, want.occurrences, got.occurrences,
					want.code_bits, got.code_bits, want.code_length, got.code_length,
					want.total_bits, got.total_bits, want.overflow, got.overflow,
					want.final_res, got.final_res);
		end
	endfunction
endclass

module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic strobe;
	sfcb_pkg::in_t item = '0;
	sfcb_pkg::out_t result;
	sfcb_scoreboard sb = new();
	int unsigned beat_no = 0;
	logic [15:0] alphabet[64];

	shannon_fano_code_builder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .strobe(strobe), .result(result)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (strobe) sb.check_result(result);
		if (start && !busy) sb.note_beat(item);
	end

	task automatic send_char(input logic [15:0] ch, input bit lst);
		if (!(beat_no > 120 && beat_no < 220) && $urandom_range(99) < 16) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start <= 1;
		item <= '{character: ch, last: lst};
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		beat_no++;
	endtask

	task automatic send_message(input int unsigned len, input int unsigned alpha);
		int unsigned k;
		for (k = 0; k < alpha; k++) alphabet[k] = 16'($urandom);
		for (k = 0; k < len; k++)
			send_char(($urandom_range(9) == 0) ? 16'($urandom)
				: alphabet[$urandom_range(alpha - 1)], k == len - 1);
	endtask

	initial begin
		int unsigned k;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_char(16'h0000, 1);
		send_char(16'hFFFF, 0);
		send_char(16'hFFFF, 0);
		send_char(16'h0000, 0);
		send_char(16'h5555, 0);
		send_char(16'hAAAA, 1);
		send_char(16'h0003, 0);
		send_char(16'h0001, 0);
		send_char(16'h0002, 0);
		send_char(16'h0002, 1);
		for (k = 0; k < 70; k++) send_char(16'(k * 997), 0);
		send_char(16'd0, 1);
		while (beat_no < 420) send_message($urandom_range(2, 30), $urandom_range(1, 12));
		start <= 0;
		while (sb.pending_codes.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("shannon_fano_code_builder verification clean");
		else
			$display("shannon_fano_code_builder verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("shannon_fano_code_builder verification failed");
		$finish;
	end
endmodule

FILE: sim.f
hdl/sfcb_pkg.sv
hdl/shannon_fano_code_builder.sv
hdl/sfcb_checker.sv
verif/tb_top.sv
